FILE: rtl/sqws_pkg.sv
// Shared types, constants and helpers for the sleep queue wake scheduler.
// No dependencies; imported by the scheduler top level and its testbench.
`timescale 1ns / 1ps

package sqws_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;

    localparam int TIME_W = 63;
    localparam int ID_W   = 8;
    localparam int PRIO_W = 6;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int RCNT_W = $clog2(MAX_RESULTS + 1);

    localparam logic REQ_SLEEP  = 1'b0;
    localparam logic REQ_TICK   = 1'b1;
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_WOKEN = 1'b1;
    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_FULL  = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] wake;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic               we;
        logic [PTR_W-1:0]   waddr;
        t_entry             wdata;
        logic               re;
        logic [PTR_W-1:0]   raddr;
    } t_mem_req;

    // Map a queue position to a slot of the circular entry store.
    function automatic logic [PTR_W-1:0] phys_idx(input logic [PTR_W-1:0] head,
                                                  input logic [CNT_W-1:0] ofs);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(ofs);
        if (s >= SUM_W'(QUEUE_DEPTH)) begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    // True when the new entry sorts at or ahead of the stored one.
    function automatic logic goes_ahead(input t_entry nw, input t_entry old);
        return (nw.wake < old.wake) || ((nw.wake == old.wake) && (nw.prio >= old.prio));
    endfunction

endpackage

FILE: rtl/sqws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sqws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sleep_queue_wake_scheduler.sv
// Top level: sorted timer queue kept in a circular entry RAM, with the
// insert/release sequencer. Depends on sqws_pkg and sqws_ram.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+----------------------------------------
//  request   | start, busy              | i_req_type, i_task_id, i_task_priority,
//            |                          | i_wake_time, i_current_time
//  result    | o_result_valid (1 cycle) | o_result_kind, o_status, o_woken_id,
//            |                          | o_woken_priority, o_last
//
// A request transfers on a rising edge with start high and busy low.
// Sleep: walks from the tail toward the head, reading each stored entry and
// moving it back one slot while the new entry goes ahead of it, then writes the
// new entry into the freed slot; a full queue answers the next cycle without
// raising busy. Tick: releases due entries from the head until the queue runs
// empty, the result limit is hit or an entry not yet due stops it. Each result
// shows the cycle after the step that makes it; one entry is touched per step.
// Reset empties the queue at once (head and count cleared); the RAM needs no pass.
// Results are never stalled; each one shows for exactly one cycle.
`timescale 1ns / 1ps

module sleep_queue_wake_scheduler (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_req_type,
    input  logic [sqws_pkg::ID_W-1:0]   i_task_id,
    input  logic [sqws_pkg::PRIO_W-1:0] i_task_priority,
    input  logic [sqws_pkg::TIME_W-1:0] i_wake_time,
    input  logic [sqws_pkg::TIME_W-1:0] i_current_time,
    output logic                       o_result_valid,
    output logic                       o_result_kind,
    output logic                       o_status,
    output logic [sqws_pkg::ID_W-1:0]   o_woken_id,
    output logic [sqws_pkg::PRIO_W-1:0] o_woken_priority,
    output logic                       o_last
);

    import sqws_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SREAD,
        ST_SCMP,
        ST_TREAD,
        ST_TCMP
    } t_state;

    t_state               r_state, n_state;
    logic [PTR_W-1:0]     r_head, n_head;
    logic [CNT_W-1:0]     r_occ, n_occ;
    logic [CNT_W-1:0]     r_j, n_j;
    logic [RCNT_W-1:0]    r_cnt, n_cnt;
    t_entry               r_new, n_new;
    logic [TIME_W-1:0]    r_now, n_now;
    logic                 r_pend, n_pend;
    logic [ID_W-1:0]      r_pend_id, n_pend_id;
    logic [PRIO_W-1:0]    r_pend_prio, n_pend_prio;

    logic                 r_out_valid, n_out_valid;
    logic                 r_out_kind, n_out_kind;
    logic                 r_out_status, n_out_status;
    logic [ID_W-1:0]      r_out_id, n_out_id;
    logic [PRIO_W-1:0]    r_out_prio, n_out_prio;
    logic                 r_out_last, n_out_last;

    t_mem_req             mem_req;
    logic [ENTRY_W-1:0]   mem_rdata;
    t_entry               rd_entry;

    sqws_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_entry = t_entry'(mem_rdata);
    assign busy     = (r_state != ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_occ        = r_occ;
        n_j          = r_j;
        n_cnt        = r_cnt;
        n_new        = r_new;
        n_now        = r_now;
        n_pend       = r_pend;
        n_pend_id    = r_pend_id;
        n_pend_prio  = r_pend_prio;
        n_out_valid  = 1'b0;
        n_out_kind   = r_out_kind;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_prio   = r_out_prio;
        n_out_last   = r_out_last;
        mem_req      = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_req_type == REQ_SLEEP) begin
                        if (r_occ == CNT_W'(QUEUE_DEPTH)) begin
                            n_out_valid  = 1'b1;
                            n_out_kind   = KIND_ACK;
                            n_out_status = STAT_FULL;
                            n_out_id     = '0;
                            n_out_prio   = '0;
                            n_out_last   = 1'b1;
                        end else begin
                            n_new.wake = i_wake_time;
                            n_new.id   = i_task_id;
                            n_new.prio = i_task_priority;
                            n_j        = r_occ;
                            n_state    = ST_SREAD;
                        end
                    end else begin
                        n_now   = i_current_time;
                        n_cnt   = '0;
                        n_pend  = 1'b0;
                        n_state = ST_TREAD;
                    end
                end
            end

            ST_SREAD: begin
                if (r_j == '0) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_head;
                    mem_req.wdata = r_new;
                    n_occ         = r_occ + CNT_W'(1);
                    n_out_valid   = 1'b1;
                    n_out_kind    = KIND_ACK;
                    n_out_status  = STAT_OK;
                    n_out_id      = '0;
                    n_out_prio    = '0;
                    n_out_last    = 1'b1;
                    n_state       = ST_IDLE;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = phys_idx(r_head, r_j - CNT_W'(1));
                    n_state       = ST_SCMP;
                end
            end

            ST_SCMP: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = phys_idx(r_head, r_j);
                if (goes_ahead(r_new, rd_entry)) begin
                    // shift the stored entry back one slot and keep walking
                    mem_req.wdata = rd_entry;
                    n_j           = r_j - CNT_W'(1);
                    n_state       = ST_SREAD;
                end else begin
                    mem_req.wdata = r_new;
                    n_occ         = r_occ + CNT_W'(1);
                    n_out_valid   = 1'b1;
                    n_out_kind    = KIND_ACK;
                    n_out_status  = STAT_OK;
                    n_out_id      = '0;
                    n_out_prio    = '0;
                    n_out_last    = 1'b1;
                    n_state       = ST_IDLE;
                end
            end

            ST_TREAD: begin
                if ((r_occ == '0) || (r_cnt == RCNT_W'(MAX_RESULTS))) begin
                    if (r_pend) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = KIND_WOKEN;
                        n_out_status = STAT_OK;
                        n_out_id     = r_pend_id;
                        n_out_prio   = r_pend_prio;
                        n_out_last   = 1'b1;
                    end
                    n_state = ST_IDLE;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_head;
                    n_state       = ST_TCMP;
                end
            end

            ST_TCMP: begin
                if (rd_entry.wake <= r_now) begin
                    // hold the due entry back until the next check so its last flag is known
                    if (r_pend) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = KIND_WOKEN;
                        n_out_status = STAT_OK;
                        n_out_id     = r_pend_id;
                        n_out_prio   = r_pend_prio;
                        n_out_last   = 1'b0;
                    end
                    n_pend      = 1'b1;
                    n_pend_id   = rd_entry.id;
                    n_pend_prio = rd_entry.prio;
                    n_head      = phys_idx(r_head, CNT_W'(1));
                    n_occ       = r_occ - CNT_W'(1);
                    n_cnt       = r_cnt + RCNT_W'(1);
                    n_state     = ST_TREAD;
                end else begin
                    if (r_pend) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = KIND_WOKEN;
                        n_out_status = STAT_OK;
                        n_out_id     = r_pend_id;
                        n_out_prio   = r_pend_prio;
                        n_out_last   = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_occ       <= '0;
            r_j         <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_occ       <= n_occ;
            r_j         <= n_j;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_new        <= n_new;
        r_now        <= n_now;
        r_pend_id    <= n_pend_id;
        r_pend_prio  <= n_pend_prio;
        r_out_kind   <= n_out_kind;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_prio   <= n_out_prio;
        r_out_last   <= n_out_last;
    end

    assign o_result_valid   = r_out_valid;
    assign o_result_kind    = r_out_kind;
    assign o_status         = r_out_status;
    assign o_woken_id       = r_out_id;
    assign o_woken_priority = r_out_prio;
    assign o_last           = r_out_last;

endmodule

FILE: tb/sv/sleep_queue_wake_scheduler_test.sv
// Self-checking testbench for sleep_queue_wake_scheduler: predicts every sleep acknowledge
// and every woken task from its own copy of the sorted queue and checks each result strobe.
// Depends on sqws_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module sleep_queue_wake_scheduler_test;
    import sqws_pkg::*;

    localparam int RANDOM_ITEMS = 480;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 2 * MAX_RESULTS + 8;

    localparam logic [TIME_W-1:0] TIME_MAX   = '1;
    localparam logic [TIME_W-1:0] EPOCH_ROOM = 63'd1048576;

    typedef struct packed {
        logic              kind;
        logic              status;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic              fin;
    } t_wake_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_req_type = REQ_SLEEP;
    logic [ID_W-1:0]      i_task_id = '0;
    logic [PRIO_W-1:0]    i_task_priority = '0;
    logic [TIME_W-1:0]    i_wake_time = '0;
    logic [TIME_W-1:0]    i_current_time = '0;
    logic                 o_result_valid;
    logic                 o_result_kind;
    logic                 o_status;
    logic [ID_W-1:0]      o_woken_id;
    logic [PRIO_W-1:0]    o_woken_priority;
    logic                 o_last;

    // Mirror of the sleep queue, position 0 is the head.
    logic [TIME_W-1:0] slot_wake [QUEUE_DEPTH];
    logic [ID_W-1:0]   slot_id   [QUEUE_DEPTH];
    logic [PRIO_W-1:0] slot_prio [QUEUE_DEPTH];
    int                fill_level = 0;

    t_wake_result      predicted_answers[$];
    int                error_count = 0;
    int                cycle_count = 0;
    logic [TIME_W-1:0] clock_now;

    sleep_queue_wake_scheduler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_task_id       (i_task_id),
        .i_task_priority (i_task_priority),
        .i_wake_time     (i_wake_time),
        .i_current_time  (i_current_time),
        .o_result_valid  (o_result_valid),
        .o_result_kind   (o_result_kind),
        .o_status        (o_status),
        .o_woken_id      (o_woken_id),
        .o_woken_priority(o_woken_priority),
        .o_last          (o_last)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Compare each result strobe against the oldest prediction.
    always @(posedge i_clk) begin
        t_wake_result exp_r;
        if (i_rst_n && o_result_valid) begin
            if (predicted_answers.size() == 0) begin
                $error("unexpected result: kind %0d id %0d", o_result_kind, o_woken_id);
                error_count++;
            end else begin
                exp_r = predicted_answers.pop_front();
                if (o_result_kind !== exp_r.kind) begin
                    $error("result_kind expected %0d got %0d", exp_r.kind, o_result_kind);
                    error_count++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status expected %0d got %0d", exp_r.status, o_status);
                    error_count++;
                end
                if (o_woken_id !== exp_r.id) begin
                    $error("woken_id expected %0d got %0d", exp_r.id, o_woken_id);
                    error_count++;
                end
                if (o_woken_priority !== exp_r.prio) begin
                    $error("woken_priority expected %0d got %0d", exp_r.prio,
                           o_woken_priority);
                    error_count++;
                end
                if (o_last !== exp_r.fin) begin
                    $error("last expected %0d got %0d", exp_r.fin, o_last);
                    error_count++;
                end
            end
        end
    end

    // Apply one accepted request to the mirrored queue and queue up its results.
    task automatic update_sleep_queue(input logic req, input logic [ID_W-1:0] id,
                                      input logic [PRIO_W-1:0] prio,
                                      input logic [TIME_W-1:0] wake,
                                      input logic [TIME_W-1:0] now);
        int pos;
        int n;
        int k;
        if (req == REQ_SLEEP) begin
            if (fill_level >= QUEUE_DEPTH) begin
                predicted_answers.push_back('{KIND_ACK, STAT_FULL, '0, '0, 1'b1});
            end else begin
                pos = fill_level;
                for (k = 0; k < fill_level; k++) begin
                    if (wake < slot_wake[k] ||
                        (wake == slot_wake[k] && prio >= slot_prio[k])) begin
                        pos = k;
                        break;
                    end
                end
                for (k = fill_level; k > pos; k--) begin
                    slot_wake[k] = slot_wake[k-1];
                    slot_id[k]   = slot_id[k-1];
                    slot_prio[k] = slot_prio[k-1];
                end
                slot_wake[pos] = wake;
                slot_id[pos]   = id;
                slot_prio[pos] = prio;
                fill_level++;
                predicted_answers.push_back('{KIND_ACK, STAT_OK, '0, '0, 1'b1});
            end
        end else begin
            n = 0;
            while (n < fill_level && n < MAX_RESULTS && slot_wake[n] <= now) n++;
            for (k = 0; k < n; k++) begin
                predicted_answers.push_back('{KIND_WOKEN, STAT_OK, slot_id[k], slot_prio[k],
                                              (k == n - 1)});
            end
            for (k = n; k < fill_level; k++) begin
                slot_wake[k-n] = slot_wake[k];
                slot_id[k-n]   = slot_id[k];
                slot_prio[k-n] = slot_prio[k];
            end
            fill_level -= n;
        end
    endtask

    // Present one request and hold it until busy is low again; start stays high afterwards.
    task automatic send_request(input logic req, input logic [ID_W-1:0] id,
                                input logic [PRIO_W-1:0] prio,
                                input logic [TIME_W-1:0] wake,
                                input logic [TIME_W-1:0] now);
        start           <= 1'b1;
        i_req_type      <= req;
        i_task_id       <= id;
        i_task_priority <= prio;
        i_wake_time     <= wake;
        i_current_time  <= now;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        update_sleep_queue(req, id, prio, wake, now);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop sending until every predicted result has come out.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (predicted_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] random_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    function automatic logic [TIME_W-1:0] fresh_epoch();
        logic [TIME_W-1:0] t;
        t = random_time();
        if (t > TIME_MAX - EPOCH_ROOM) t = t - EPOCH_ROOM;
        return t;
    endfunction

    task automatic test_empty_ticks();
        send_request(REQ_TICK, '0, '0, '0, '0);
        send_request(REQ_TICK, '0, '0, '0, TIME_MAX);
    endtask

    // Ties on wake time: higher priority first, then newest first.
    task automatic test_ordering();
        send_request(REQ_SLEEP, 8'd1, 6'd10, 63'd5, '0);
        send_request(REQ_SLEEP, 8'd2, 6'd20, 63'd5, '0);
        send_request(REQ_SLEEP, 8'd3, 6'd10, 63'd5, '0);
        send_request(REQ_SLEEP, 8'd0, 6'd0, 63'd0, TIME_MAX);
        send_request(REQ_SLEEP, 8'd255, 6'd63, TIME_MAX, '0);
        // garbage in the sleep-only fields of a tick
        send_request(REQ_TICK, 8'd255, 6'd63, TIME_MAX, 63'd4);
        send_request(REQ_TICK, '0, '0, '0, 63'd5);
    endtask

    // Fill to capacity, get one rejection, then release the whole queue in one tick.
    task automatic test_queue_full();
        int k;
        for (k = fill_level; k < QUEUE_DEPTH; k++) begin
            send_request(REQ_SLEEP, ID_W'(16 + k), PRIO_W'(k), TIME_W'(100 + k), '0);
        end
        send_request(REQ_SLEEP, 8'd170, 6'd42, 63'd1, TIME_MAX);
        send_request(REQ_TICK, 8'd85, 6'd21, random_time(), TIME_MAX);
    endtask

    task automatic send_random_request();
        int                r;
        logic [PRIO_W-1:0] prio;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) prio = PRIO_W'($urandom_range(0, 63));
        else prio = PRIO_W'($urandom_range(28, 31));
        if (r < 5) begin
            send_request(REQ_SLEEP, ID_W'($urandom_range(0, 255)), PRIO_W'($urandom_range(0, 63)),
                         random_time(), random_time());
        end else if (r < 8) begin
            send_request(REQ_TICK, ID_W'($urandom), PRIO_W'($urandom), random_time(),
                         random_time());
        end else if (r < 11) begin
            // flush everything and move to a new time base
            send_request(REQ_TICK, ID_W'($urandom), PRIO_W'($urandom), random_time(), TIME_MAX);
            clock_now = fresh_epoch();
        end else if (r < 58) begin
            send_request(REQ_SLEEP, ID_W'($urandom_range(0, 255)), prio,
                         clock_now + TIME_W'($urandom_range(0, 40)), random_time());
        end else begin
            clock_now = clock_now + TIME_W'($urandom_range(0, 12));
            send_request(REQ_TICK, ID_W'($urandom), PRIO_W'($urandom), random_time(), clock_now);
        end
    endtask

    task automatic test_random_traffic();
        int   sent;
        int   burst;
        logic paused;
        sent = 0;
        paused = 1'b0;
        clock_now = fresh_epoch();
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                send_random_request();
                sent++;
            end
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                drain_results();
                paused = 1'b1;
            end else if ($urandom_range(0, 3) != 0) begin
                hold_off($urandom_range(1, 24));
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_ticks();
        test_ordering();
        test_queue_full();
        test_random_traffic();
        drain_results();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
